FILE: design/two_class_priority_insertion_sort_top_assert.svh
`ifndef TWO_CLASS_PRIORITY_INSERTION_SORT_TOP_ASSERT_SVH
`define TWO_CLASS_PRIORITY_INSERTION_SORT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tps_pkg.sv
`default_nettype none

package tps_pkg;

  localparam int unsigned MAX_TASKS_DEF = 32;

  localparam int unsigned PRIO_W     = 11;
  localparam int unsigned KEY_W      = 10;
  localparam int unsigned SYS_LIM_W  = 9;
  localparam int unsigned USR_LIM_W  = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TASK_IDX_W = 5;

  localparam logic [SYS_LIM_W-1:0] SYS_LIM_RST = 9'd50;
  localparam logic [USR_LIM_W-1:0] USR_LIM_RST = 10'd255;

  localparam logic LIST_SYS  = 1'b0;
  localparam logic LIST_USER = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYSTEM_LIMIT = 1'b0,
    REG_USER_LIMIT   = 1'b1
  } tps_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } tps_state_e;

  // Port controls of the list memory.
  typedef struct packed {
    logic we;
    logic re;
  } tps_mem_ctl_t;

  // Which list a task goes to; neither bit set means the task is dropped.
  typedef struct packed {
    logic to_sys;
    logic to_user;
  } tps_class_t;

endpackage

`default_nettype wire

FILE: design/tps_store.sv
`default_nettype none

module tps_store #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 15
) (
  input  logic                    clk_i,
  input  tps_pkg::tps_mem_ctl_t   ctl_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [DW-1:0]           wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [DW-1:0]           rdata_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/tps_ctrl.sv
`default_nettype none

module tps_ctrl #(
  parameter int unsigned MAX_TASKS = tps_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tps_pkg::KEY_W-1:0]       key_i,
  input  tps_pkg::tps_class_t             cls_i,
  input  logic                            batch_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tps_pkg::TASK_IDX_W-1:0]  task_index_o,
  output logic                            list_select_o,
  output logic                            end_marker_o,
  output logic                            overflow_o,
  output logic                            last_o,
  output tps_pkg::tps_mem_ctl_t           mem_ctl_o,
  output logic [$clog2(MAX_TASKS):0]      mem_waddr_o,
  output logic [tps_pkg::KEY_W+$clog2(MAX_TASKS)-1:0] mem_wdata_o,
  output logic [$clog2(MAX_TASKS):0]      mem_raddr_o,
  input  logic [tps_pkg::KEY_W+$clog2(MAX_TASKS)-1:0] mem_rdata_i
);

  localparam int unsigned PW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  tps_pkg::tps_state_e state_q, state_d;

  logic [CW-1:0] arrival_q, arrival_d;
  logic [CW-1:0] sys_cnt_q, sys_cnt_d;
  logic [CW-1:0] usr_cnt_q, usr_cnt_d;
  logic          ovf_q, ovf_d;
  logic          lst_q, lst_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          be_q, be_d;
  logic          out_list_q, out_list_d;
  logic [CW-1:0] out_i_q, out_i_d;
  logic          out_end_q, out_end_d;
  logic          out_last_q, out_last_d;

  logic [tps_pkg::KEY_W-1:0]      key_q, key_d;
  logic [PW-1:0]                  arr_q, arr_d;
  logic [tps_pkg::TASK_IDX_W-1:0] out_idx_q, out_idx_d;

  logic [tps_pkg::KEY_W-1:0] rd_key;
  logic [PW-1:0]             rd_idx;
  logic [CW-1:0]             in_cnt;
  logic [CW-1:0]             out_cnt;

  assign rd_key  = mem_rdata_i[tps_pkg::KEY_W+PW-1:PW];
  assign rd_idx  = mem_rdata_i[PW-1:0];
  assign in_cnt  = cls_i.to_user ? usr_cnt_q : sys_cnt_q;
  assign out_cnt = (out_list_q == tps_pkg::LIST_USER) ? usr_cnt_q : sys_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tps_pkg::ST_IDLE;
      arrival_q  <= '0;
      sys_cnt_q  <= '0;
      usr_cnt_q  <= '0;
      ovf_q      <= 1'b0;
      lst_q      <= tps_pkg::LIST_SYS;
      pos_q      <= '0;
      be_q       <= 1'b0;
      out_list_q <= tps_pkg::LIST_SYS;
      out_i_q    <= '0;
      out_end_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      arrival_q  <= arrival_d;
      sys_cnt_q  <= sys_cnt_d;
      usr_cnt_q  <= usr_cnt_d;
      ovf_q      <= ovf_d;
      lst_q      <= lst_d;
      pos_q      <= pos_d;
      be_q       <= be_d;
      out_list_q <= out_list_d;
      out_i_q    <= out_i_d;
      out_end_q  <= out_end_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    arr_q     <= arr_d;
    out_idx_q <= out_idx_d;
  end

  always_comb begin
    state_d    = state_q;
    arrival_d  = arrival_q;
    sys_cnt_d  = sys_cnt_q;
    usr_cnt_d  = usr_cnt_q;
    ovf_d      = ovf_q;
    lst_d      = lst_q;
    pos_d      = pos_q;
    be_d       = be_q;
    out_list_d = out_list_q;
    out_i_d    = out_i_q;
    out_end_d  = out_end_q;
    out_last_d = out_last_q;
    key_d      = key_q;
    arr_d      = arr_q;
    out_idx_d  = out_idx_q;

    mem_ctl_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    in_ready_o  = (state_q == tps_pkg::ST_IDLE);
    out_valid_o = (state_q == tps_pkg::ST_OUT_HOLD);

    case (state_q)
      tps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (arrival_q == CW'(MAX_TASKS)) begin
            ovf_d   = 1'b1;
            state_d = batch_end_i ? tps_pkg::ST_OUT_RD : tps_pkg::ST_IDLE;
          end else begin
            arrival_d = arrival_q + 1'b1;
            if (cls_i.to_sys || cls_i.to_user) begin
              key_d = key_i;
              arr_d = arrival_q[PW-1:0];
              lst_d = cls_i.to_user;
              be_d  = batch_end_i;
              pos_d = PW'(in_cnt);
              // Fetch the current tail so the first compare can start next cycle.
              mem_ctl_o.re = (in_cnt != '0);
              mem_raddr_o  = {cls_i.to_user, PW'(in_cnt - 1'b1)};
              state_d      = tps_pkg::ST_SHIFT;
            end else begin
              state_d = batch_end_i ? tps_pkg::ST_OUT_RD : tps_pkg::ST_IDLE;
            end
          end
        end
      end

      tps_pkg::ST_SHIFT: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = {lst_q, pos_q};
        if ((pos_q != '0) && (key_q < rd_key)) begin
          // Move the larger entry up one slot and prefetch the one below it.
          mem_wdata_o  = mem_rdata_i;
          pos_d        = pos_q - 1'b1;
          mem_ctl_o.re = (pos_q != PW'(1));
          mem_raddr_o  = {lst_q, PW'(pos_q - PW'(2))};
        end else begin
          mem_wdata_o = {key_q, arr_q};
          if (lst_q == tps_pkg::LIST_USER) begin
            usr_cnt_d = usr_cnt_q + 1'b1;
          end else begin
            sys_cnt_d = sys_cnt_q + 1'b1;
          end
          state_d = be_q ? tps_pkg::ST_OUT_RD : tps_pkg::ST_IDLE;
        end
      end

      tps_pkg::ST_OUT_RD: begin
        if (out_i_q < out_cnt) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = {out_list_q, PW'(out_i_q)};
          state_d      = tps_pkg::ST_OUT_LD;
        end else begin
          out_idx_d  = '0;
          out_end_d  = 1'b1;
          out_last_d = (out_list_q == tps_pkg::LIST_USER);
          state_d    = tps_pkg::ST_OUT_HOLD;
        end
      end

      tps_pkg::ST_OUT_LD: begin
        out_idx_d  = tps_pkg::TASK_IDX_W'(rd_idx);
        out_end_d  = 1'b0;
        out_last_d = 1'b0;
        state_d    = tps_pkg::ST_OUT_HOLD;
      end

      tps_pkg::ST_OUT_HOLD: begin
        if (out_ready_i) begin
          if (out_end_q) begin
            if (out_list_q == tps_pkg::LIST_USER) begin
              sys_cnt_d  = '0;
              usr_cnt_d  = '0;
              arrival_d  = '0;
              ovf_d      = 1'b0;
              out_list_d = tps_pkg::LIST_SYS;
              out_i_d    = '0;
              state_d    = tps_pkg::ST_IDLE;
            end else begin
              out_list_d = tps_pkg::LIST_USER;
              out_i_d    = '0;
              state_d    = tps_pkg::ST_OUT_RD;
            end
          end else begin
            out_i_d = out_i_q + 1'b1;
            state_d = tps_pkg::ST_OUT_RD;
          end
        end
      end

      default: begin
        state_d = tps_pkg::ST_IDLE;
      end
    endcase
  end

  assign task_index_o  = out_idx_q;
  assign list_select_o = out_list_q;
  assign end_marker_o  = out_end_q;
  assign overflow_o    = ovf_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

FILE: design/two_class_priority_insertion_sort_top.sv
// Insertion: a transaction is taken in ST_IDLE; a dropped one needs no more, while a listed
//   one walks ST_SHIFT, moving each larger entry up one slot, and ends with the final write.
// Readout: after the batch-end transaction, each list entry passes the read, load and show
//   states and each end marker the select and show states; show holds while out_ready_i is low.
// Reset restores the limits to 50 and 255 and clears the counts and the overflow flag; the
//   list memory keeps stale contents, never read because the counts bound every access.
`default_nettype none

module two_class_priority_insertion_sort_top #(
  parameter int unsigned MAX_TASKS = tps_pkg::MAX_TASKS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // Task input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [tps_pkg::PRIO_W-1:0]    priority_req_i,
  input  logic                                 batch_end_i,
  // Sorted result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tps_pkg::TASK_IDX_W-1:0]       task_index_o,
  output logic                                 list_select_o,
  output logic                                 end_marker_o,
  output logic                                 overflow_o,
  output logic                                 last_o
);

  // One memory holds both lists: the top address bit picks the list and the
  // remaining bits are the position inside it. Each entry is {key, arrival}.
  localparam int unsigned PW = $clog2(MAX_TASKS);
  localparam int unsigned AW = PW + 1;
  localparam int unsigned DW = tps_pkg::KEY_W + PW;

  logic [tps_pkg::SYS_LIM_W-1:0] sys_lim_q;
  logic [tps_pkg::USR_LIM_W-1:0] usr_lim_q;

  // Limit registers. Writes must arrive only while the block is idle, which the block itself
  // does not enforce; then the classification below never sees a limit change mid-task.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_lim_q <= tps_pkg::SYS_LIM_RST;
      usr_lim_q <= tps_pkg::USR_LIM_RST;
    end else if (cfg_we_i) begin
      case (tps_pkg::tps_reg_e'(cfg_idx_i))
        tps_pkg::REG_SYSTEM_LIMIT: sys_lim_q <= cfg_data_i[tps_pkg::SYS_LIM_W-1:0];
        tps_pkg::REG_USER_LIMIT:   usr_lim_q <= cfg_data_i[tps_pkg::USR_LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A negative priority belongs to neither list. For a non-negative one the
  // low ten bits are the value itself and serve as the unsigned sort key.
  logic                      prio_nonneg;
  logic [tps_pkg::KEY_W-1:0] prio_mag;
  logic [tps_pkg::KEY_W-1:0] sys_lim_ext;
  tps_pkg::tps_class_t       cls;

  assign prio_nonneg  = ~priority_req_i[tps_pkg::PRIO_W-1];
  assign prio_mag     = priority_req_i[tps_pkg::KEY_W-1:0];
  assign sys_lim_ext  = tps_pkg::KEY_W'(sys_lim_q);
  assign cls.to_sys   = prio_nonneg && (prio_mag < sys_lim_ext);
  // With crossed limits this term is never true, so the user list stays empty.
  assign cls.to_user  = prio_nonneg && (prio_mag >= sys_lim_ext) && (prio_mag <= usr_lim_q);

  tps_pkg::tps_mem_ctl_t mem_ctl;
  logic [AW-1:0]         mem_waddr;
  logic [DW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DW-1:0]         mem_rdata;

  // The sequencer runs the stable insertion as a read-compare-write walk down
  // the list, prefetching the next lower entry while it writes the current
  // one, and then streams both lists with their end markers.
  tps_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_i        (prio_mag),
    .cls_i        (cls),
    .batch_end_i  (batch_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .task_index_o (task_index_o),
    .list_select_o(list_select_o),
    .end_marker_o (end_marker_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Simple dual-port list memory with a registered read port. During a shift
  // the write goes two slots above the one being read, so they never collide.
  tps_store #(
    .AW(AW),
    .DW(DW)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

FILE: design/tps_assert_checker.sv
`default_nettype none
`include "two_class_priority_insertion_sort_top_assert.svh"

module tps_assert_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [tps_pkg::TASK_IDX_W-1:0]       task_index_o,
  input logic                                 list_select_o,
  input logic                                 end_marker_o,
  input logic                                 overflow_o,
  input logic                                 last_o
);

  logic                           out_stall;
  logic                           run_done;
  logic                           marker_shown;
  logic                           user_end;
  logic [tps_pkg::TASK_IDX_W+3:0] shown;

  assign out_stall    = out_valid_o && !out_ready_i;
  assign run_done     = out_valid_o && out_ready_i && last_o;
  assign marker_shown = out_valid_o && end_marker_o;
  assign user_end     = end_marker_o && (list_select_o == tps_pkg::LIST_USER);
  assign shown        = {task_index_o, list_select_o, end_marker_o, overflow_o, last_o};

  // The block handles one batch phase at a time: no input while a result is shown.
  `TPS_ASSERT_IMPL(a_ready_excl, in_ready_o, !out_valid_o, "input ready during readout")

  `TPS_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(shown), "stalled result changed")

  `TPS_ASSERT_IMPL(a_last_user_end, out_valid_o && last_o, user_end, "last flag on a wrong result")

  `TPS_ASSERT_IMPL(a_marker_idx, marker_shown, task_index_o == '0, "nonzero index in end marker")

  `TPS_ASSERT_NEXT(a_batch_clear, run_done, in_ready_o && !overflow_o, "batch not cleared")

endmodule

bind two_class_priority_insertion_sort_top tps_assert_checker u_assert_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .task_index_o (task_index_o),
  .list_select_o(list_select_o),
  .end_marker_o (end_marker_o),
  .overflow_o   (overflow_o),
  .last_o       (last_o)
);

`default_nettype wire
